// ===== hw/rtl/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// Best-fit allocator package
// Field widths, opcodes and register map shared by the allocator files.
// ----------------------------------------------------------------------------
package bfa_pkg;

  // Field widths of the input and result words.
  localparam int OPCODE_W   = 2;
  localparam int SLOT_W     = 5;
  localparam int PORT_SIZE_W = 16;

  // Configuration register.
  localparam int ACTIVE_W     = 6;
  localparam int ACTIVE_RESET = 32;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_ADDR_W   = 3;

  // Register indexes.
  localparam logic REG_ACTIVE_BLOCKS = 1'b0;

  // Opcodes.
  localparam logic [OPCODE_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_REQUEST = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd2;

  typedef logic [OPCODE_W-1:0]    opcode_t;
  typedef logic [SLOT_W-1:0]      slot_t;
  typedef logic [PORT_SIZE_W-1:0] port_size_t;

endpackage

// ===== hw/rtl/bfa_in_if.sv =====
// ----------------------------------------------------------------------------
// Allocator input channel
// Valid/ready channel that carries one command word.
// ----------------------------------------------------------------------------
interface bfa_in_if;
  import bfa_pkg::*;

  logic       valid;
  logic       ready;
  opcode_t    opcode;
  slot_t      block_slot;
  port_size_t size;

  modport source (output valid, output opcode, output block_slot, output size,
                  input ready);
  modport sink   (input valid, input opcode, input block_slot, input size,
                  output ready);
endinterface

// ===== hw/rtl/bfa_out_if.sv =====
// ----------------------------------------------------------------------------
// Allocator result channel
// Valid/ready channel that carries one result word.
// ----------------------------------------------------------------------------
interface bfa_out_if;
  import bfa_pkg::*;

  logic       valid;
  logic       ready;
  logic       granted;
  slot_t      block_index;
  port_size_t leftover;

  modport source (output valid, output granted, output block_index,
                  output leftover, input ready);
  modport sink   (input valid, input granted, input block_index,
                  input leftover, output ready);
endinterface

// ===== hw/rtl/best_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// Best-fit block allocator
// Keeps a table of block sizes with used flags and grants best-fit requests.
// ----------------------------------------------------------------------------
// Every accepted word returns exactly one result word. A load word writes one
// table entry's size and frees that entry; a release word frees every entry;
// both pass through the done state to the result register. A request word
// scans the first active_blocks entries (capped at NUM_BLOCKS) one entry per
// cycle through a single subtract-and-compare unit fed by the registered read
// port of the size RAM, so the compare of each entry trails its read by that
// RAM register. Every word commits its result from the done state; the
// commit waits until the result register is free, that is until the pending
// result word is taken. The block takes one word at a time: in_ch.ready is
// high only while the sequencer is idle, but it does not wait for the result
// register to be drained, so the next word is taken while the previous result
// is still pending. The smallest leftover wins and ties go to the lowest
// index. Block sizes are not cleared at reset; a request must not reach an
// entry that was never loaded.
module best_fit_block_allocator #(
  parameter int NUM_BLOCKS = 32,
  parameter int SIZE_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  bfa_in_if.sink                       in_ch,
  bfa_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bfa_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [bfa_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [bfa_pkg::CFG_DATA_W-1:0] prdata,
  output logic                         pready
);
  import bfa_pkg::*;

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam int CMP_W = (CNT_W > ACTIVE_W) ? CNT_W : ACTIVE_W;

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]           state_r;
  logic [ACTIVE_W-1:0]  active_r;
  logic [NUM_BLOCKS-1:0] used_r;

  // Scan bookkeeping.
  logic [CNT_W-1:0]     cnt_r;
  logic [CNT_W-1:0]     lim_r;
  logic                 pend_r;
  logic [IDX_W-1:0]     pidx_r;
  logic [SIZE_BITS-1:0] req_r;
  logic                 found_r;
  logic [IDX_W-1:0]     best_idx_r;
  logic [SIZE_BITS-1:0] best_left_r;

  // Result register.
  logic                 out_valid_r;
  logic                 granted_r;
  slot_t                index_r;
  port_size_t           leftover_r;

  logic                 in_fire;
  logic                 cfg_wr;
  logic                 slot_ok;
  logic [SIZE_BITS-1:0] in_size;
  logic [SIZE_BITS-1:0] rd_data;
  logic [SIZE_BITS:0]   diff_full;
  logic                 better;
  logic                 scan_more;
  logic                 out_free;
  logic [CMP_W-1:0]     active_ext;
  logic [CMP_W-1:0]     lim_ext;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_size     = SIZE_BITS'(in_ch.size);
  assign slot_ok     = int'(in_ch.block_slot) < NUM_BLOCKS;

  // The search covers no more entries than the table holds.
  assign active_ext = CMP_W'(active_r);
  assign lim_ext    = (active_ext > CMP_W'(NUM_BLOCKS)) ? CMP_W'(NUM_BLOCKS) : active_ext;

  // Block size table. Loads write at acceptance; the scan reads one entry per
  // cycle and the data comes back in the following cycle, tagged by pidx_r.
  bfa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (NUM_BLOCKS)
  ) u_size_ram (
    .clk     (clk),
    .wr_en   (in_fire && (in_ch.opcode == OP_LOAD) && slot_ok),
    .wr_addr (IDX_W'(in_ch.block_slot)),
    .wr_data (in_size),
    .rd_addr (cnt_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  // The shared unit: one subtract gives both the fit test (no borrow) and the
  // leftover, then one compare against the best leftover so far.
  assign diff_full = {1'b0, rd_data} - {1'b0, req_r};
  assign better    = pend_r && !used_r[pidx_r] && !diff_full[SIZE_BITS] &&
                     (!found_r || (diff_full[SIZE_BITS-1:0] < best_left_r));
  assign scan_more = (cnt_r != lim_r);
  assign out_free  = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // A taken result word is dropped unless a new one is committed below.
      if (out_ch.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            found_r <= 1'b0;
            req_r   <= in_size;
            cnt_r   <= '0;
            lim_r   <= CNT_W'(lim_ext);
            pend_r  <= 1'b0;
            if (in_ch.opcode == OP_REQUEST) begin
              state_r <= S_SCAN;
            end else begin
              state_r <= S_DONE;
            end
            if (in_ch.opcode == OP_LOAD && slot_ok) begin
              used_r[IDX_W'(in_ch.block_slot)] <= 1'b0;
            end
            if (in_ch.opcode == OP_RELEASE) begin
              used_r <= '0;
            end
          end
        end
        S_SCAN: begin
          pend_r <= scan_more;
          pidx_r <= cnt_r[IDX_W-1:0];
          if (scan_more) begin
            cnt_r <= cnt_r + 1'b1;
          end
          if (better) begin
            found_r     <= 1'b1;
            best_idx_r  <= pidx_r;
            best_left_r <= diff_full[SIZE_BITS-1:0];
          end
          if (!scan_more && !pend_r) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          // Wait for the result register, then commit the result word.
          if (out_free) begin
            out_valid_r <= 1'b1;
            granted_r   <= found_r;
            index_r     <= found_r ? SLOT_W'(best_idx_r) : '0;
            leftover_r  <= found_r ? PORT_SIZE_W'(best_left_r) : '0;
            if (found_r) begin
              used_r[best_idx_r] <= 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.granted     = granted_r;
  assign out_ch.block_index = index_r;
  assign out_ch.leftover    = leftover_r;

  // Configuration port: one register; pready is tied high. The word address is
  // paddr[2]; the byte offset bits are ignored.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_W'(ACTIVE_RESET);
    end else if (cfg_wr && paddr[2] == REG_ACTIVE_BLOCKS) begin
      active_r <= pwdata[ACTIVE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_ACTIVE_BLOCKS) ? CFG_DATA_W'(active_r) : '0;

endmodule

// ===== hw/rtl/bfa_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== dv/best_fit_block_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// Best-fit block allocator testbench
// Drives load, request, release and unused command words into the allocator
// under random source gaps and sink stalls, predicts every result word with a
// scoreboard class that keeps its own copy of the size table, the used flags
// and the active_blocks register, and checks each result word field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module best_fit_block_allocator_tb;
  import bfa_pkg::*;

  localparam int BLOCKS = 32;

  // The block defines no name for the fourth opcode; it must change nothing.
  localparam opcode_t OP_UNUSED = 2'd3;

  // Index of a register that does not exist; writes to it must be ignored.
  localparam int unsigned REG_UNMAPPED = 1;

  // Longest stretch without any accepted word before the run is declared hung.
  // The slowest correct stretch is a source gap, a request scan, a sink stall
  // and a register update.
  localparam int STALL_LIMIT = 2000;

  localparam int PHASES = 9;
  localparam int WORDS_PER_PHASE = 148;

  typedef struct packed {
    logic       granted;
    slot_t      block_index;
    port_size_t leftover;
  } alloc_result_t;

  // Keeps the allocator's expected state and the queue of result words that
  // the accepted command words have caused but that have not come back yet.
  class alloc_scoreboard;
    port_size_t        blk_size [BLOCKS];
    bit                blk_used [BLOCKS];
    logic [ACTIVE_W-1:0] active_reg;
    alloc_result_t     expected_grants [$];
    int                errors;

    function new();
      foreach (blk_size[i]) begin
        blk_size[i] = '0;
        blk_used[i] = 1'b0;
      end
      active_reg = ACTIVE_W'(ACTIVE_RESET);
      errors = 0;
    endfunction

    function void set_active(logic [CFG_DATA_W-1:0] value);
      active_reg = value[ACTIVE_W-1:0];
    endfunction

    function int pending();
      return expected_grants.size();
    endfunction

    // Applies one accepted command word to the state and queues its result.
    function void note_word(opcode_t op, slot_t slot, port_size_t req);
      alloc_result_t res;
      int            count;
      bit            found;
      int            best;
      port_size_t    best_left;
      res = '0;
      found = 1'b0;
      best = 0;
      best_left = '0;
      case (op)
        OP_LOAD: begin
          if (int'(slot) < BLOCKS) begin
            blk_size[slot] = req;
            blk_used[slot] = 1'b0;
          end
        end
        OP_RELEASE: begin
          foreach (blk_used[i]) blk_used[i] = 1'b0;
        end
        OP_REQUEST: begin
          // A count above the table size is clamped to the table size.
          count = (int'(active_reg) > BLOCKS) ? BLOCKS : int'(active_reg);
          for (int j = 0; j < count; j++) begin
            if (!blk_used[j] && blk_size[j] >= req) begin
              // Strictly smaller leftover wins, so ties keep the lowest index.
              if (!found || (blk_size[j] - req) < best_left) begin
                found = 1'b1;
                best = j;
                best_left = blk_size[j] - req;
              end
            end
          end
          if (found) begin
            blk_used[best] = 1'b1;
            res.granted = 1'b1;
            res.block_index = slot_t'(best);
            res.leftover = best_left;
          end
        end
        default: ;
      endcase
      expected_grants.push_back(res);
    endfunction

    function void check_word(logic granted, slot_t block_index, port_size_t leftover);
      alloc_result_t exp_res;
      if (expected_grants.size() == 0) begin
        $error("result word with no expected result pending");
        errors++;
        return;
      end
      exp_res = expected_grants.pop_front();
      if (granted !== exp_res.granted) begin
        $error("granted: expected %0d, actual %0d", exp_res.granted, granted);
        errors++;
      end
      if (block_index !== exp_res.block_index) begin
        $error("block_index: expected %0d, actual %0d", exp_res.block_index, block_index);
        errors++;
      end
      if (leftover !== exp_res.leftover) begin
        $error("leftover: expected %0d, actual %0d", exp_res.leftover, leftover);
        errors++;
      end
    endfunction

    function void check_register(logic [CFG_DATA_W-1:0] readback);
      if (readback !== CFG_DATA_W'(active_reg)) begin
        $error("active_blocks: expected %0d, actual %0d", active_reg, readback);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  bfa_in_if  in_ch ();
  bfa_out_if out_ch ();

  best_fit_block_allocator i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  alloc_scoreboard sb = new();

  // Stimulus-side view of the table. It only steers the random words toward
  // interesting sizes and keeps every request away from entries that were
  // never loaded, whose contents the block leaves undefined.
  port_size_t  gen_size   [BLOCKS];
  bit          gen_loaded [BLOCKS];
  int unsigned gen_active;

  // Idling switches for the source and the sink; both go off for the last phase.
  bit in_gaps;
  bit out_stalls;

  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Sink side: ready stays high except for random stall bursts.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_stalls && $urandom_range(0, 9) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // Monitor and watchdog. Both channels are sampled at the rising edge, before
  // the block's own updates for that edge land, so an accepted word is exactly
  // what was on the wires when valid and ready were both high.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        sb.check_word(out_ch.granted, out_ch.block_index, out_ch.leftover);
      end
      if (in_ch.valid && in_ch.ready) begin
        sb.note_word(in_ch.opcode, in_ch.block_slot, in_ch.size);
      end
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("best_fit_block_allocator: mismatch");
        $finish;
      end
    end
  end

  // Presents one command word and returns at the edge where it is accepted.
  // A random gap may come first; valid is only lowered when a gap is taken, so
  // back-to-back words keep it high without a second assignment in one step.
  task automatic send_word(opcode_t op, slot_t slot, port_size_t sz);
    if (in_gaps && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.block_slot <= slot;
    in_ch.size       <= sz;
    if (op == OP_LOAD) begin
      gen_size[slot]   = sz;
      gen_loaded[slot] = 1'b1;
    end
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // One APB write followed by a read of active_blocks, which must show the
  // new value (or the old one when the write went to an unmapped index).
  task automatic write_register(int unsigned index, logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(4 * index);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (index == int'(REG_ACTIVE_BLOCKS)) begin
      sb.set_active(value);
      gen_active = (value[ACTIVE_W-1:0] > BLOCKS) ? BLOCKS : value[ACTIVE_W-1:0];
    end
    @(posedge clk);
    psel  <= 1'b1;
    paddr <= CFG_ADDR_W'(4 * int'(REG_ACTIVE_BLOCKS));
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.check_register(readback);
    @(posedge clk);
  endtask

  // Stops the source, lets every expected result word come back, and only then
  // touches the register, so the block is idle when the count changes.
  task automatic reconfigure(int unsigned index, logic [CFG_DATA_W-1:0] value);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_register(index, value);
  endtask

  // Random word. Most are requests and loads; request sizes are drawn close to
  // the loaded blocks and load sizes from narrow bands, so exact fits, near misses and ties show up often.
  task automatic send_random();
    int unsigned pick;
    int unsigned first_gap;
    int unsigned j;
    int unsigned d;
    opcode_t     op;
    slot_t       slot;
    port_size_t  sz;
    pick = $urandom_range(0, 99);
    slot = slot_t'($urandom_range(0, BLOCKS - 1));
    sz   = port_size_t'($urandom);
    if (pick < 50) begin
      op = OP_REQUEST;
    end else if (pick < 90) begin
      op = OP_LOAD;
      if (gen_active > 0 && $urandom_range(0, 3) != 0) begin
        slot = slot_t'($urandom_range(0, gen_active - 1));
      end
    end else if (pick < 96) begin
      op = OP_RELEASE;
    end else begin
      op = OP_UNUSED;
    end

    if (op == OP_REQUEST) begin
      // A request may only scan loaded entries: fill the first hole instead.
      first_gap = BLOCKS;
      for (int k = BLOCKS - 1; k >= 0; k--) begin
        if (!gen_loaded[k]) first_gap = k;
      end
      if (first_gap < gen_active) begin
        op   = OP_LOAD;
        slot = slot_t'(first_gap);
      end else begin
        case ($urandom_range(0, 7))
          0: sz = '0;
          1: sz = '1;
          2, 3: sz = port_size_t'($urandom);
          default: begin
            if (gen_active > 0) begin
              j  = $urandom_range(0, gen_active - 1);
              d  = $urandom_range(0, 2);
              sz = (gen_size[j] > d) ? gen_size[j] - port_size_t'(d) : '0;
              if ($urandom_range(0, 5) == 0) sz = gen_size[j] + 1'b1;
            end
          end
        endcase
      end
    end

    if (op == OP_LOAD) begin
      case ($urandom_range(0, 7))
        0: sz = '0;
        1: sz = '1;
        2, 3: sz = port_size_t'($urandom);
        4: sz = port_size_t'(16 + $urandom_range(0, 2));
        5: sz = port_size_t'(100 + $urandom_range(0, 2));
        6: sz = port_size_t'(1000 + $urandom_range(0, 2));
        default: sz = port_size_t'(40000 + $urandom_range(0, 2));
      endcase
    end
    send_word(op, slot, sz);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] setting;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.opcode     <= OP_LOAD;
    in_ch.block_slot <= '0;
    in_ch.size       <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    in_gaps    = 1'b1;
    out_stalls = 1'b1;
    idle_cycles = 0;
    gen_active = ACTIVE_RESET;
    foreach (gen_size[i]) begin
      gen_size[i]   = '0;
      gen_loaded[i] = 1'b0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. With no active blocks a request can never be granted and
    // scans nothing, so it is safe before any entry is loaded.
    reconfigure(int'(REG_ACTIVE_BLOCKS), 32'd0);
    write_register(REG_UNMAPPED, 32'hFFFF_FFFF);
    send_word(OP_REQUEST, 5'd31, 16'hFFFF);
    send_word(OP_LOAD, 5'd0, 16'hFFFF);
    send_word(OP_LOAD, 5'd1, 16'h0000);
    // The unused opcode must leave the table alone and return an empty result.
    send_word(OP_UNUSED, 5'd31, 16'hFFFF);
    send_word(OP_LOAD, 5'd2, 16'd100);
    send_word(OP_LOAD, 5'd3, 16'd100);

    // Two entries: an exact fit beats the huge block, then the table runs out.
    reconfigure(int'(REG_ACTIVE_BLOCKS), 32'd2);
    send_word(OP_REQUEST, 5'd0, 16'h0000);
    send_word(OP_REQUEST, 5'd0, 16'h0000);
    send_word(OP_REQUEST, 5'd0, 16'h0000);
    send_word(OP_RELEASE, 5'd0, 16'h0000);
    send_word(OP_REQUEST, 5'd0, 16'hFFFF);
    // Reloading an entry frees it; a request one above its size does not fit.
    send_word(OP_LOAD, 5'd0, 16'h8000);
    send_word(OP_REQUEST, 5'd0, 16'h8001);
    send_word(OP_REQUEST, 5'd0, 16'h7FFF);

    // Four entries: two equal blocks tie and the lower index must win.
    reconfigure(int'(REG_ACTIVE_BLOCKS), 32'd4);
    send_word(OP_REQUEST, 5'd0, 16'd50);
    send_word(OP_REQUEST, 5'd0, 16'd100);
    send_word(OP_REQUEST, 5'd0, 16'd1);

    // Random phases, each under its own count. Counts above the table size
    // must behave like a full table; odd phases put junk in the unused bits
    // of the write data. The last phase runs with no idling on either side.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: setting = 32'd63;
        1: setting = 32'd1;
        2: setting = 32'd32;
        3: setting = 32'd17;
        4: setting = 32'd33;
        5: setting = 32'd0;
        6: setting = 32'd31;
        7: setting = CFG_DATA_W'($urandom_range(0, 63));
        default: setting = 32'd32;
      endcase
      if (p % 2 == 1) setting = setting | ($urandom & 32'hFFFF_FFC0);
      in_gaps    = (p % 3 != 2) && (p != PHASES - 1);
      out_stalls = (p % 4 != 3) && (p != PHASES - 1);
      reconfigure(int'(REG_ACTIVE_BLOCKS), setting);
      repeat (WORDS_PER_PHASE) send_random();
    end

    // Drain and give the block time to show any stray result word.
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("best_fit_block_allocator: match");
    end else begin
      $display("best_fit_block_allocator: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/bfa_pkg.sv
hw/rtl/bfa_in_if.sv
hw/rtl/bfa_out_if.sv
hw/rtl/bfa_ram.sv
hw/rtl/best_fit_block_allocator.sv
dv/best_fit_block_allocator_tb.sv
